FILE: sv/pfe_pkg.sv
package pfe_pkg;

  localparam int LETTER_W    = 5;
  localparam int NUM_LETTERS = 26;
  localparam int NUM_CELLS   = 25;
  localparam int Q_DEPTH     = 2;

  localparam logic [LETTER_W-1:0] LETTER_Z = 5'd25;
  localparam logic [LETTER_W-1:0] FILLER   = 5'd23;

  // Cell of each letter a..z in the key square; j shares the cell of i.
  localparam logic [LETTER_W-1:0] CELL_OF [NUM_LETTERS] = '{
    5'd7,  5'd11, 5'd12, 5'd13, 5'd0,  5'd9,  5'd14, 5'd15, 5'd4,
    5'd4,  5'd16, 5'd6,  5'd2,  5'd17, 5'd5,  5'd3,  5'd18, 5'd10,
    5'd1,  5'd19, 5'd20, 5'd21, 5'd22, 5'd23, 5'd8,  5'd24
  };

  // Key square, row-major: e s m p i / o l a y f / r b c d g / h k n q t / u v w x z
  localparam logic [LETTER_W-1:0] KEY_SEQ [NUM_CELLS] = '{
    5'd4,  5'd18, 5'd12, 5'd15, 5'd8,
    5'd14, 5'd11, 5'd0,  5'd24, 5'd5,
    5'd17, 5'd1,  5'd2,  5'd3,  5'd6,
    5'd7,  5'd10, 5'd13, 5'd16, 5'd19,
    5'd20, 5'd21, 5'd22, 5'd23, 5'd25
  };

  typedef struct packed {
    logic [LETTER_W-1:0] plain_letter;
    logic                end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [LETTER_W-1:0] cipher_letter;
    logic                last_of_message;
  } out_item_t;

  typedef struct packed {
    logic [LETTER_W-1:0] first;
    logic [LETTER_W-1:0] second;
    logic                last;
  } bigram_t;

endpackage

FILE: sv/pfe_queue.sv
module pfe_queue import pfe_pkg::*; #(
  parameter int  DEPTH  = 2,
  parameter type item_t = bigram_t
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output item_t head_item,
  output logic  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t             mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign empty     = (cnt_r == '0);
  assign head_item = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push into full queue");
`endif

endmodule

FILE: sv/pfe_front.sv
module pfe_front import pfe_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  input  in_item_t in_item,
  output logic     in_full,
  output logic     bq_push,
  output bigram_t  bq_item,
  input  logic     bq_full
);

  logic [LETTER_W-1:0] held_r;
  logic                held_v_r;
  bigram_t             p0_r, p1_r;
  logic                p0_v_r, p1_v_r;

  logic [LETTER_W-1:0] letter;
  logic                eom, accept, drain, same;
  bigram_t             nb0, nb1;
  logic [1:0]          n_new;

  assign letter  = (in_item.plain_letter > LETTER_Z) ? LETTER_Z : in_item.plain_letter;
  assign eom     = in_item.end_of_message;
  assign same    = (CELL_OF[letter] == CELL_OF[held_r]);
  assign drain   = p0_v_r && !bq_full;
  assign in_full = p1_v_r || (p0_v_r && bq_full);
  assign accept  = in_push && !in_full;
  assign bq_push = drain;
  assign bq_item = p0_r;

  // Split one letter into zero, one or two bigrams
  always_comb begin
    nb0   = '{first: held_r, second: letter, last: eom};
    nb1   = '{first: letter, second: FILLER, last: 1'b1};
    n_new = 2'd0;
    if (held_v_r) begin
      if (same) begin
        nb0   = '{first: held_r, second: FILLER, last: 1'b0};
        n_new = eom ? 2'd2 : 2'd1;
      end else begin
        n_new = 2'd1;
      end
    end else if (eom) begin
      nb0   = '{first: letter, second: FILLER, last: 1'b1};
      n_new = 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r   <= '0;
      held_v_r <= 1'b0;
      p0_v_r   <= 1'b0;
      p1_v_r   <= 1'b0;
    end else begin
      if (drain) begin
        p0_r   <= p1_r;
        p0_v_r <= p1_v_r;
        p1_v_r <= 1'b0;
      end
      if (accept) begin
        p0_r   <= nb0;
        p1_r   <= nb1;
        p0_v_r <= (n_new != 2'd0);
        p1_v_r <= (n_new == 2'd2);
        if (eom || (held_v_r && !same)) begin
          held_r   <= '0;
          held_v_r <= 1'b0;
        end else begin
          held_r   <= letter;
          held_v_r <= 1'b1;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_slot_order: assert property (@(posedge clk) disable iff (!rst_n)
    p1_v_r |-> p0_v_r)
    else $error("second bigram slot set without first");
  a_eom_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && eom) |=> !held_v_r)
    else $error("letter still held after end of message");
`endif

endmodule

FILE: sv/pfe_back.sv
module pfe_back import pfe_pkg::*; #(
  parameter int GRID_SIDE = 5
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      bq_empty,
  input  bigram_t   bq_head,
  output logic      bq_pop,
  output logic      oq_push,
  output out_item_t oq_item,
  input  logic      oq_full
);

  localparam int RC_W = $clog2(GRID_SIDE);

  logic [RC_W-1:0]     row_lt [NUM_LETTERS];
  logic [RC_W-1:0]     col_lt [NUM_LETTERS];
  logic [LETTER_W-1:0] key_at [GRID_SIDE][GRID_SIDE];
  logic                occ_at [GRID_SIDE][GRID_SIDE];

  // Constant lookup tables, built at elaboration
  for (genvar i = 0; i < NUM_LETTERS; i++) begin : g_lt
    assign row_lt[i] = RC_W'(int'(CELL_OF[i]) / GRID_SIDE);
    assign col_lt[i] = RC_W'(int'(CELL_OF[i]) % GRID_SIDE);
  end

  for (genvar r = 0; r < GRID_SIDE; r++) begin : g_row
    for (genvar c = 0; c < GRID_SIDE; c++) begin : g_col
      localparam int IDX = r * GRID_SIDE + c;
      assign occ_at[r][c] = (IDX < NUM_CELLS);
      assign key_at[r][c] = (IDX < NUM_CELLS) ? KEY_SEQ[IDX % NUM_CELLS] : '0;
    end
  end

  logic                phase_r;
  logic [RC_W-1:0]     r1, c1, r2, c2;
  logic [RC_W:0]       nc1, nc2, nr1, nr2;
  logic [LETTER_W-1:0] o1, o2;
  logic                wr;

  assign r1 = row_lt[bq_head.first];
  assign c1 = col_lt[bq_head.first];
  assign r2 = row_lt[bq_head.second];
  assign c2 = col_lt[bq_head.second];

  always_comb begin
    nc1 = {1'b0, c1} + (RC_W+1)'(1);
    nc2 = {1'b0, c2} + (RC_W+1)'(1);
    nr1 = {1'b0, r1} + (RC_W+1)'(1);
    nr2 = {1'b0, r2} + (RC_W+1)'(1);
    // Wrap past the edge or onto an empty cell
    if (nc1 == (RC_W+1)'(GRID_SIDE)) nc1 = '0;
    else if (!occ_at[r1][nc1[RC_W-1:0]]) nc1 = '0;
    if (nc2 == (RC_W+1)'(GRID_SIDE)) nc2 = '0;
    else if (!occ_at[r2][nc2[RC_W-1:0]]) nc2 = '0;
    if (nr1 == (RC_W+1)'(GRID_SIDE)) nr1 = '0;
    else if (!occ_at[nr1[RC_W-1:0]][c1]) nr1 = '0;
    if (nr2 == (RC_W+1)'(GRID_SIDE)) nr2 = '0;
    else if (!occ_at[nr2[RC_W-1:0]][c2]) nr2 = '0;

    if (r1 == r2) begin
      o1 = key_at[r1][nc1[RC_W-1:0]];
      o2 = key_at[r2][nc2[RC_W-1:0]];
    end else if (c1 == c2) begin
      o1 = key_at[nr1[RC_W-1:0]][c1];
      o2 = key_at[nr2[RC_W-1:0]][c2];
    end else begin
      o1 = occ_at[r1][c2] ? key_at[r1][c2] : key_at[r1][c1];
      o2 = occ_at[r2][c1] ? key_at[r2][c1] : key_at[r2][c2];
    end
  end

  assign wr      = !bq_empty && !oq_full;
  assign oq_push = wr;
  assign bq_pop  = wr && phase_r;
  assign oq_item = phase_r ? '{cipher_letter: o2, last_of_message: bq_head.last}
                           : '{cipher_letter: o1, last_of_message: 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
    end else if (wr) begin
      phase_r <= !phase_r;
    end
  end

`ifndef SYNTHESIS
  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> !bq_empty)
    else $error("second letter pending with no bigram");
  a_pop_second: assert property (@(posedge clk) disable iff (!rst_n)
    bq_pop |-> (phase_r && oq_push))
    else $error("bigram dropped before both letters left");
`endif

endmodule

FILE: sv/playfair_stream_encryptor_top.sv
// Playfair stream encryptor. Plaintext letters (0 = a .. 25 = z, codes above
// 25 taken as z) enter one per item on the in_ queue port with end_of_message
// on the final letter; cipher letters leave on the out_ queue port, two per
// bigram, with last_of_message on the final one. Letters pair up in order; a
// repeated letter (j counts as i) or a lone final letter is closed with the
// filler x, so one item yields zero, two or four cipher letters. The front
// accepts one item per cycle unless it still holds a second bigram from the
// previous item or the bigram queue is full; the back works on one bigram at
// a time and sends out one cipher letter per cycle while a bigram waits and
// the result queue has room, popping the bigram with its second letter. An
// item's first cipher letter passes the front's bigram slot, the bigram queue
// and the result queue before it shows on the out_ ports. GRID_SIDE (5 or 6)
// sets the key square side; in a 6-wide square the 25 letters fill it
// row-major and the rest stay empty.
module playfair_stream_encryptor_top import pfe_pkg::*; #(
  parameter int GRID_SIDE = 5
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  input  in_item_t  in_item,
  output logic      in_full,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);

  logic    bq_push, bq_full, bq_pop, bq_empty;
  bigram_t bq_in, bq_head;

  logic      oq_push, oq_full;
  out_item_t oq_in;

  // Front: pair letters into bigrams, insert filler, track the held letter
  pfe_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_item (in_item),
    .in_full (in_full),
    .bq_push (bq_push),
    .bq_item (bq_in),
    .bq_full (bq_full)
  );

  // Decouple the front from the back so either side can stall alone
  pfe_queue #(
    .DEPTH  (Q_DEPTH),
    .item_t (bigram_t)
  ) u_bigram_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (bq_push),
    .push_item (bq_in),
    .full      (bq_full),
    .pop       (bq_pop),
    .head_item (bq_head),
    .empty     (bq_empty)
  );

  // Back: find both letters' cells; emit one cipher letter a cycle unless stalled
  pfe_back #(
    .GRID_SIDE (GRID_SIDE)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .bq_empty (bq_empty),
    .bq_head  (bq_head),
    .bq_pop   (bq_pop),
    .oq_push  (oq_push),
    .oq_item  (oq_in),
    .oq_full  (oq_full)
  );

  // Result queue: hold finished letters while the consumer stalls
  pfe_queue #(
    .DEPTH  (Q_DEPTH),
    .item_t (out_item_t)
  ) u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (oq_push),
    .push_item (oq_in),
    .full      (oq_full),
    .pop       (out_pop),
    .head_item (out_item),
    .empty     (out_empty)
  );

endmodule
